// ===== hdl/complex_fir_matched_filter_top_macros.svh =====
// Assertion macros for the complex FIR matched filter.
// Used by the top level; expects signals named clk and arst_n in scope.
`ifndef COMPLEX_FIR_MATCHED_FILTER_TOP_MACROS_SVH
`define COMPLEX_FIR_MATCHED_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CFMF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("complex FIR same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define CFMF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("complex FIR next-cycle check failed");
`else
`define CFMF_ASSERT_SAME(lbl, ante, cons)
`define CFMF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/cfmf_pkg.sv =====
// Shared types and constants for the complex FIR matched filter.
// No dependencies; every other file of the block but the assertion macros header uses this package.
package cfmf_pkg;

	localparam int MAX_TAPS_DEF    = 16;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int TAPS_RESET      = 16;

	localparam int FIELD_W     = 16;
	localparam int COEF_IDX_W  = 4;
	localparam int OUT_W       = 40;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 5;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_TAPS    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CONJ    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_REVERSE = 2'd2;

	// Input item function codes.
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_COEF   = 1'b1;

	// Control bundle broadcast from the sequencer to every tap cell.
	typedef struct packed {
		logic shift;
		logic en1;
		logic en2;
		logic conj;
		logic rev;
	} cfmf_cell_ctrl_t;

endpackage

// ===== hdl/cfmf_channels.sv =====
// Handshake channel interfaces of the complex FIR matched filter.
// Depends on cfmf_pkg for the field widths.
interface cfmf_in_if;
	import cfmf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic signed [FIELD_W-1:0] value_i;
	logic signed [FIELD_W-1:0] value_q;
	logic [COEF_IDX_W-1:0]     coef_index;
	logic                      last_in;
	modport source (output valid, func, value_i, value_q, coef_index, last_in, input ready);
	modport sink (input valid, func, value_i, value_q, coef_index, last_in, output ready);
endinterface

interface cfmf_out_if;
	import cfmf_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] out_i;
	logic signed [OUT_W-1:0] out_q;
	logic                    last_out;
	modport source (output valid, out_i, out_q, last_out, input ready);
	modport sink (input valid, out_i, out_q, last_out, output ready);
endinterface

interface cfmf_cfg_if;
	import cfmf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ===== hdl/cfmf_cell.sv =====
// One tap cell: delay register, weight register, effective weight, complex product.
// Depends on cfmf_pkg for the control bundle type.
module cfmf_cell #(
	parameter int SB = cfmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfmf_pkg::cfmf_cell_ctrl_t  ctrl,
	input  logic                       active,
	input  logic signed [SB-1:0]       d_prev_re,
	input  logic signed [SB-1:0]       d_prev_im,
	output logic signed [SB-1:0]       d_re,
	output logic signed [SB-1:0]       d_im,
	input  logic                       wr_en,
	input  logic signed [SB-1:0]       wr_re,
	input  logic signed [SB-1:0]       wr_im,
	output logic signed [SB-1:0]       w_re,
	output logic signed [SB-1:0]       w_im,
	input  logic signed [SB-1:0]       wrev_re,
	input  logic signed [SB-1:0]       wrev_im,
	output logic signed [2*SB+1:0]     sum_re,
	output logic signed [2*SB+1:0]     sum_im
);
	localparam int PW = 2*SB+1;
	localparam int SW = 2*SB+2;

	logic signed [SB-1:0] d_re_q, d_im_q, w_re_q, w_im_q;
	logic signed [SB-1:0] eff_re_q;
	logic signed [SB:0]   eff_im_q;
	logic signed [SB-1:0] sel_re, sel_im;
	logic signed [SB:0]   sel_im_x, eff_im_n;
	logic signed [PW-1:0] prr_s1, pqq_s1, prq_s1, pqr_s1;
	logic signed [SW-1:0] sum_re_s2, sum_im_s2;

	// Weight seen by this tap: own or mirrored, optionally conjugated.
	// The imaginary part carries one extra bit so the most negative value negates exactly.
	always_comb begin
		sel_re   = ctrl.rev ? wrev_re : w_re_q;
		sel_im   = ctrl.rev ? wrev_im : w_im_q;
		sel_im_x = (SB+1)'(sel_im);
		eff_im_n = ctrl.conj ? -sel_im_x : sel_im_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_re_q   <= '0;
			d_im_q   <= '0;
			w_re_q   <= '0;
			w_im_q   <= '0;
			eff_re_q <= '0;
			eff_im_q <= '0;
		end else begin
			if (ctrl.shift) begin
				d_re_q <= d_prev_re;
				d_im_q <= d_prev_im;
			end
			if (wr_en) begin
				w_re_q <= wr_re;
				w_im_q <= wr_im;
			end
			eff_re_q <= active ? sel_re : '0;
			eff_im_q <= active ? eff_im_n : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en1) begin
			prr_s1 <= d_re_q * eff_re_q;
			pqq_s1 <= d_im_q * eff_im_q;
			prq_s1 <= d_re_q * eff_im_q;
			pqr_s1 <= d_im_q * eff_re_q;
		end
		if (ctrl.en2) begin
			sum_re_s2 <= SW'(prr_s1) - SW'(pqq_s1);
			sum_im_s2 <= SW'(prq_s1) + SW'(pqr_s1);
		end
	end

	assign d_re   = d_re_q;
	assign d_im   = d_im_q;
	assign w_re   = w_re_q;
	assign w_im   = w_im_q;
	assign sum_re = sum_re_s2;
	assign sum_im = sum_im_s2;

endmodule

// ===== hdl/cfmf_adder_tree.sv =====
// Registered binary adder tree with per-level valid and backpressure.
// Sums the complex tap products; the root register is the output register.
// Depends on cfmf_pkg for the default leaf count and widths.
module cfmf_adder_tree #(
	parameter int N  = cfmf_pkg::MAX_TAPS_DEF,
	parameter int LW = 2*cfmf_pkg::SAMPLE_BITS_DEF+2,
	parameter int AW = LW + $clog2(N)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	output logic                 in_ready,
	input  logic signed [LW-1:0] leaf_re [N],
	input  logic signed [LW-1:0] leaf_im [N],
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_last,
	output logic signed [AW-1:0] out_re,
	output logic signed [AW-1:0] out_im
);
	localparam int L  = $clog2(N);
	localparam int NP = 1 << L;

	logic signed [AW-1:0] lf_re [NP];
	logic signed [AW-1:0] lf_im [NP];
	logic signed [AW-1:0] node_re_q [NP-1];
	logic signed [AW-1:0] node_im_q [NP-1];
	logic                 vld_q  [L];
	logic                 last_q [L];
	logic                 ld     [L];

	for (genvar j = 0; j < NP; j++) begin : g_leaf
		if (j < N) begin : g_used
			assign lf_re[j] = AW'(leaf_re[j]);
			assign lf_im[j] = AW'(leaf_im[j]);
		end else begin : g_pad
			assign lf_re[j] = '0;
			assign lf_im[j] = '0;
		end
	end

	// Depth 0 is the root; a level loads when empty or when the level above drains it.
	for (genvar d = 0; d < L; d++) begin : g_level
		if (d == 0) begin : g_root
			assign ld[d] = !vld_q[d] || out_ready;
		end else begin : g_inner
			assign ld[d] = !vld_q[d] || ld[d-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[d]  <= 1'b0;
				last_q[d] <= 1'b0;
			end else if (ld[d]) begin
				if (d == L-1) begin
					vld_q[d]  <= in_valid;
					last_q[d] <= in_last;
				end else begin
					vld_q[d]  <= vld_q[(d == L-1) ? d : d+1];
					last_q[d] <= last_q[(d == L-1) ? d : d+1];
				end
			end
		end
	end

	for (genvar k = 0; k < NP-1; k++) begin : g_node
		localparam int D  = $clog2(k+2) - 1;
		localparam int C0 = 2*k + 1;
		logic signed [AW-1:0] ca_re, ca_im, cb_re, cb_im;
		if (C0 >= NP-1) begin : g_from_leaf
			assign ca_re = lf_re[C0-(NP-1)];
			assign ca_im = lf_im[C0-(NP-1)];
			assign cb_re = lf_re[C0+1-(NP-1)];
			assign cb_im = lf_im[C0+1-(NP-1)];
		end else begin : g_from_node
			assign ca_re = node_re_q[C0];
			assign ca_im = node_im_q[C0];
			assign cb_re = node_re_q[C0+1];
			assign cb_im = node_im_q[C0+1];
		end
		always_ff @(posedge clk) begin
			if (ld[D]) begin
				node_re_q[k] <= ca_re + cb_re;
				node_im_q[k] <= ca_im + cb_im;
			end
		end
	end

	assign in_ready  = ld[L-1];
	assign out_valid = vld_q[0];
	assign out_last  = last_q[0];
	assign out_re    = node_re_q[0];
	assign out_im    = node_im_q[0];

endmodule

// ===== hdl/complex_fir_matched_filter_top.sv =====
// Complex FIR matched filter, top level: tap cell row, flush sequencer, adder tree.
// Pipeline: delay line, cell products, cell complex sum, then one register per tree level.
// Throughput: one item per cycle while the output is ready; a sample marked last holds off
// input while the flush outputs are generated. Asynchronous active-low reset clears the
// delay line, the weights and the pipeline valid flags, and loads the configuration defaults.
`include "complex_fir_matched_filter_top_macros.svh"

module complex_fir_matched_filter_top #(
	parameter int MAX_TAPS    = cfmf_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = cfmf_pkg::SAMPLE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cfmf_cfg_if.sink   cfg,
	cfmf_in_if.sink    samples,
	cfmf_out_if.source results
);
	import cfmf_pkg::*;

	localparam int TW      = $clog2(MAX_TAPS+1);
	localparam int IW      = $clog2(MAX_TAPS);
	localparam int SB      = SAMPLE_BITS;
	localparam int CSW     = 2*SB+2;
	localparam int AW      = CSW + $clog2(MAX_TAPS);
	localparam int T_RESET = (TAPS_RESET > MAX_TAPS) ? MAX_TAPS : TAPS_RESET;

	// Configuration. The tap count is stored already clamped to 1..MAX_TAPS.
	logic [TW-1:0] t_act_q, taps_clamped;
	logic          conj_q, rev_q;

	// Input side and sequencing.
	logic                 in_acc, smp_acc, coef_acc, flushing, shift;
	logic                 ld0, ld1, ld2, tree_rdy;
	logic [TW-1:0]        flush_cnt_q;
	logic                 vld_s0, last_s0, vld_s1, last_s1, vld_s2, last_s2;
	logic signed [SB-1:0] smp_re, smp_im, head_re, head_im;

	// Cell row wiring.
	cfmf_cell_ctrl_t      ctrl;
	logic signed [SB-1:0] d_re [MAX_TAPS];
	logic signed [SB-1:0] d_im [MAX_TAPS];
	logic signed [SB-1:0] w_row_re [MAX_TAPS];
	logic signed [SB-1:0] w_row_im [MAX_TAPS];
	logic signed [SB-1:0] wrev_re [MAX_TAPS];
	logic signed [SB-1:0] wrev_im [MAX_TAPS];
	logic signed [CSW-1:0] sum_re [MAX_TAPS];
	logic signed [CSW-1:0] sum_im [MAX_TAPS];

	logic signed [AW-1:0] tree_re, tree_im;

	// ------------------------------------------------------------------
	// Configuration port. Writes are always taken; an unknown index is ignored.
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_comb begin
		if (cfg.data == '0) begin
			taps_clamped = TW'(1);
		end else if (32'(cfg.data) > MAX_TAPS) begin
			taps_clamped = TW'(MAX_TAPS);
		end else begin
			taps_clamped = TW'(cfg.data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_act_q <= TW'(T_RESET);
			conj_q  <= 1'b0;
			rev_q   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_TAPS:    t_act_q <= taps_clamped;
				REG_CONJ:    conj_q  <= cfg.data[0];
				REG_REVERSE: rev_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline handshake. Stage 0 is the delay line itself: once a sample
	// has been shifted in, the line must not move again until the cells
	// have captured their products (ld1). Stage 1 holds the products,
	// stage 2 the per-cell complex sums, and the tree follows. Each stage
	// loads when it is empty or its content moves on, so bubbles collapse
	// and input keeps flowing while a finished result waits at the output.
	// Coefficient writes use the same gate, so a pending sample never sees
	// a weight that arrived after it.
	// ------------------------------------------------------------------
	assign ld2 = !vld_s2 || tree_rdy;
	assign ld1 = !vld_s1 || ld2;
	assign ld0 = !vld_s0 || ld1;

	assign flushing      = (flush_cnt_q != '0);
	assign samples.ready = ld0 && !flushing;
	assign in_acc        = samples.valid && samples.ready;
	assign smp_acc       = in_acc && (samples.func == FUNC_SAMPLE);
	assign coef_acc      = in_acc && (samples.func == FUNC_COEF);

	// During a flush a zero sample enters the line every cycle the line may move.
	assign shift = smp_acc || (ld0 && flushing);

	// The low SAMPLE_BITS bits of the field are the sample (zero-extended when wider).
	assign smp_re  = SB'($unsigned(samples.value_i));
	assign smp_im  = SB'($unsigned(samples.value_q));
	assign head_re = flushing ? '0 : smp_re;
	assign head_im = flushing ? '0 : smp_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_cnt_q <= '0;
			vld_s0      <= 1'b0;
			last_s0     <= 1'b0;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			vld_s2      <= 1'b0;
			last_s2     <= 1'b0;
		end else begin
			if (ld0) begin
				vld_s0  <= shift;
				// The final output of a block is the last flush step, or the
				// sample itself when only one tap is active.
				last_s0 <= flushing ? (flush_cnt_q == TW'(1))
				                    : (samples.last_in && (t_act_q == TW'(1)));
			end
			if (smp_acc && samples.last_in) begin
				flush_cnt_q <= t_act_q - TW'(1);
			end else if (ld0 && flushing) begin
				flush_cnt_q <= flush_cnt_q - TW'(1);
			end
			if (ld1) begin
				vld_s1  <= vld_s0;
				last_s1 <= last_s0;
			end
			if (ld2) begin
				vld_s2  <= vld_s1;
				last_s2 <= last_s1;
			end
		end
	end

	assign ctrl.shift = shift;
	assign ctrl.en1   = ld1;
	assign ctrl.en2   = ld2;
	assign ctrl.conj  = conj_q;
	assign ctrl.rev   = rev_q;

	// ------------------------------------------------------------------
	// Row of tap cells. Cell i holds delay position i (newest at cell 0)
	// and weight i. In matched-filter mode cell i uses weight T-1-i, picked
	// from the weight row; cells at or beyond T contribute zero.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < MAX_TAPS; i++) begin : g_tap
		logic [TW-1:0]        ridx;
		logic signed [SB-1:0] prev_re, prev_im;
		logic                 active, wr_en;

		assign ridx       = t_act_q - TW'(i) - TW'(1);
		assign wrev_re[i] = w_row_re[ridx[IW-1:0]];
		assign wrev_im[i] = w_row_im[ridx[IW-1:0]];
		assign active     = (TW'(i) < t_act_q);
		assign wr_en      = coef_acc && (32'(samples.coef_index) == i);

		if (i == 0) begin : g_head
			assign prev_re = head_re;
			assign prev_im = head_im;
		end else begin : g_link
			assign prev_re = d_re[i-1];
			assign prev_im = d_im[i-1];
		end

		cfmf_cell #(
			.SB(SB)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.active    (active),
			.d_prev_re (prev_re),
			.d_prev_im (prev_im),
			.d_re      (d_re[i]),
			.d_im      (d_im[i]),
			.wr_en     (wr_en),
			.wr_re     (smp_re),
			.wr_im     (smp_im),
			.w_re      (w_row_re[i]),
			.w_im      (w_row_im[i]),
			.wrev_re   (wrev_re[i]),
			.wrev_im   (wrev_im[i]),
			.sum_re    (sum_re[i]),
			.sum_im    (sum_im[i])
		);
	end

	// ------------------------------------------------------------------
	// Adder tree; its root register is the output register of the block.
	// Results are resized to the 40-bit output width (sign-extended with the default sizes).
	// ------------------------------------------------------------------
	cfmf_adder_tree #(
		.N  (MAX_TAPS),
		.LW (CSW),
		.AW (AW)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_last   (last_s2),
		.in_ready  (tree_rdy),
		.leaf_re   (sum_re),
		.leaf_im   (sum_im),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_last  (results.last_out),
		.out_re    (tree_re),
		.out_im    (tree_im)
	);

	assign results.out_i = OUT_W'(tree_re);
	assign results.out_q = OUT_W'(tree_im);

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	// A flush count only moves when the delay line moves.
	`CFMF_ASSERT_NEXT(a_flush_hold, flushing && !shift, $stable(flush_cnt_q))
	// The final flush step leaves a marked item in the delay line stage.
	`CFMF_ASSERT_NEXT(a_flush_end, (flush_cnt_q == TW'(1)) && shift,
		(flush_cnt_q == '0) && vld_s0 && last_s0)
	// A shifted-in sample stays pending until the cells capture it.
	`CFMF_ASSERT_NEXT(a_s0_hold, vld_s0 && !ld1, vld_s0 && $stable(last_s0))
	// Input is never taken while a pending sample waits for capture.
	`CFMF_ASSERT_SAME(a_no_overrun, in_acc, !vld_s0 || ld1)

endmodule
